### rtl/qrv_pkg.sv
`default_nettype none
package qrv_pkg;

    // Internal widths
    localparam int XW     = 49;   // sign-extended input word
    localparam int QW     = 32;   // clamped quaternion component
    localparam int MW     = 31;   // component magnitude
    localparam int SQW    = 61;   // magnitude squared
    localparam int SUMW   = 62;   // sum of squares
    localparam int RW     = 64;   // root datapath
    localparam int SW     = 31;   // vector-part length
    localparam int RSTEPS = 32;   // root cells, one result bit each
    localparam int GUARD  = 28;
    localparam int CW     = 62;   // rotator x/y
    localparam int AW     = 64;   // angle accumulator, Q3.60
    localparam int CSTEPS = 48;   // rotator cells
    localparam int QTW    = 32;   // quotient bits
    localparam int DREMW  = 62;   // divider remainder
    localparam int AQW    = 31;   // angle in Q3.28
    localparam int PRODW  = 63;
    localparam int LIMW   = 31;
    localparam int TW     = 36;   // signed turn before clamping

    localparam logic [LIMW-1:0] LIMIT_RESET = LIMW'(1);
    localparam longint TWO_PI_Q28 = 64'sd1686629714;
    localparam int ANGLE_FRAC = 60;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] res;
    } root_t;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [AW-1:0] acc;
    } cordic_t;

    typedef struct packed {
        logic [DREMW-1:0] rem;
        logic [QTW-1:0]   quot;
        logic [SW-1:0]    den;
    } div_t;

    // Bit-by-bit long division, used only for elaboration-time constants
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/inv) in Q3.60 by truncated power series
    function automatic longint atan_inv(input longint inv);
        logic [63:0] p;
        logic [63:0] term;
        longint sum;
        p = udiv(64'd1 << ANGLE_FRAC, 64'(inv));
        sum = 0;
        for (int k = 0; k < 48; k++) begin
            if (p != 0) begin
                term = udiv(p, 64'(2 * k + 1));
                sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
                p = udiv(p, 64'(inv * inv));
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in Q3.60; pi/4 by Machin's formula
    function automatic longint atan_const(input int i);
        longint sum;
        logic [63:0] term;
        int e;
        sum = 0;
        if (i == 0) begin
            sum = 4 * atan_inv(5) - atan_inv(239);
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = ANGLE_FRAC - i * (2 * k + 1);
                if (e >= 0) begin
                    term = udiv(64'd1 << e, 64'(2 * k + 1));
                    sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
                end
            end
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

### rtl/qrv_root_cell.sv
`default_nettype none
module qrv_root_cell #(
    parameter int STEP = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire qrv_pkg::root_t din,
    output qrv_pkg::root_t     dout
);
    import qrv_pkg::*;

    localparam logic [RW-1:0] BIT = RW'(1) << (62 - 2 * STEP);

    logic [RW-1:0] trial;
    root_t         dout_next;

    // Try one result bit
    always_comb begin
        trial = din.res + BIT;
        if (din.rem >= trial) begin
            dout_next.rem = din.rem - trial;
            dout_next.res = (din.res >> 1) + BIT;
        end else begin
            dout_next.rem = din.rem;
            dout_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout <= dout_next;
        end
    end
endmodule
`default_nettype wire

### rtl/qrv_cordic_cell.sv
`default_nettype none
module qrv_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire qrv_pkg::cordic_t din,
    output qrv_pkg::cordic_t     dout
);
    import qrv_pkg::*;

    localparam logic signed [AW-1:0] ATAN = AW'(atan_const(STEP));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cordic_t              dout_next;

    // Rotate toward the x axis by atan(2^-STEP)
    always_comb begin
        dx = din.py >>> STEP;
        dy = din.px >>> STEP;
        if (din.py >= 0) begin
            dout_next.px  = din.px + dx;
            dout_next.py  = din.py - dy;
            dout_next.acc = din.acc + ATAN;
        end else begin
            dout_next.px  = din.px - dx;
            dout_next.py  = din.py + dy;
            dout_next.acc = din.acc - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout <= dout_next;
        end
    end
endmodule
`default_nettype wire

### rtl/qrv_div_cell.sv
`default_nettype none
module qrv_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire qrv_pkg::div_t din,
    output qrv_pkg::div_t     dout
);
    import qrv_pkg::*;

    logic [DREMW:0] den_sh;
    div_t           dout_next;

    // Settle one quotient bit
    always_comb begin
        den_sh    = (DREMW + 1)'(din.den) << SHIFT;
        dout_next = din;
        if ((DREMW + 1)'(din.rem) >= den_sh) begin
            dout_next.rem         = DREMW'((DREMW + 1)'(din.rem) - den_sh);
            dout_next.quot[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout <= dout_next;
        end
    end
endmodule
`default_nettype wire

### rtl/quaternion_to_rotation_vector.sv
// Channel   | Handshake             | Carries
// ----------+-----------------------+---------------------------------------------
// input     | s_valid / s_ready     | s_trans_x..z (Q16.16), s_quat_w..z (Q2.30)
// result    | m_valid / m_ready     | m_move_x..z, m_turn_x..z (Q4.28), m_small_path
// config    | cfg_valid / cfg_ready | cfg_data: small-angle limit (Q2.30)
//
// One request per cycle while the result register is free or taken; from acceptance the path to the result
// register runs through 32 root cells, 48 rotator cells and the multiply stages around them.
// A stalled result freezes the whole cell row; s_ready follows the result register.
// Reset (aresetn low, synchronous) empties the row and sets the limit to 1 LSB.
`default_nettype none
module quaternion_to_rotation_vector #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_trans_x,
    input  wire logic signed [DATA_WIDTH-1:0] s_trans_y,
    input  wire logic signed [DATA_WIDTH-1:0] s_trans_z,
    input  wire logic signed [DATA_WIDTH-1:0] s_quat_w,
    input  wire logic signed [DATA_WIDTH-1:0] s_quat_x,
    input  wire logic signed [DATA_WIDTH-1:0] s_quat_y,
    input  wire logic signed [DATA_WIDTH-1:0] s_quat_z,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [qrv_pkg::LIMW-1:0]     cfg_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_move_x,
    output logic signed [DATA_WIDTH-1:0]      m_move_y,
    output logic signed [DATA_WIDTH-1:0]      m_move_z,
    output logic signed [DATA_WIDTH-1:0]      m_turn_x,
    output logic signed [DATA_WIDTH-1:0]      m_turn_y,
    output logic signed [DATA_WIDTH-1:0]      m_turn_z,
    output logic                              m_small_path
);
    import qrv_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int ST_SUM  = 2;
    localparam int ST_ROOT = ST_SUM + RSTEPS;
    localparam int ST_DEC  = ST_ROOT + 1;
    localparam int ST_CORD = ST_DEC + CSTEPS - 1;
    localparam int ST_ANG  = ST_CORD + 1;
    localparam int ST_MUL  = ST_ANG + 2;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int RDLY    = ST_ANG - (ST_DEC + RSTEPS) + 1;

    localparam int OFF_MAG   = 3 * DW;
    localparam int OFF_SGN   = OFF_MAG + 3 * MW;
    localparam int OFF_SMALL = OFF_SGN + 3;
    localparam int SIDEW     = OFF_SMALL + 1;

    localparam longint HI  = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint LIM = (HI < TWO_PI_Q28) ? HI : TWO_PI_Q28;
    localparam logic signed [TW-1:0] LIM_P = TW'(LIM);
    localparam logic signed [TW-1:0] LIM_N = -TW'(LIM);

    logic                  en;
    logic [LIMW-1:0]       limit_reg;
    logic                  vld_reg  [0:ST_OUT];
    logic [SIDEW-1:0]      side_reg [0:ST_OUT];
    logic signed [QW-1:0]  w_reg    [0:ST_ROOT];
    logic [SQW-1:0]        sq_reg   [3];
    logic [SUMW-1:0]       sum_reg;
    root_t                 root_d   [RSTEPS+1];
    cordic_t               cord_d   [CSTEPS];
    div_t                  div_d    [3][RSTEPS+1];
    logic [QTW-1:0]        ratio_reg[3][RDLY];
    logic [AQW-1:0]        aq_reg;
    logic [PRODW-1:0]      prod_reg [3];
    logic signed [DW-1:0]  turn_reg [3];

    logic signed [QW-1:0]  q_in     [4];
    logic [SIDEW-1:0]      side_in;
    logic [SW-1:0]         root_s;
    logic                  is_small;
    logic [SIDEW-1:0]      side_dec;
    cordic_t               cord_init;
    logic signed [TW-1:0]  turn_next[3];

    // Saturate a widened component to [-1, 1] in Q2.30
    function automatic logic signed [QW-1:0] clamp_q(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] one;
        one = XW'(64'sd1 <<< 30);
        if (v > one) begin
            return QW'(one);
        end else if (v < -one) begin
            return QW'(-one);
        end
        return QW'(v);
    endfunction

    assign en        = !vld_reg[ST_OUT] || m_ready;
    assign s_ready   = en && aresetn;
    assign cfg_ready = aresetn;

    // Hold the small-angle limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Advance the valid bits along the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ST_OUT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= ST_OUT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Clamp the quaternion and split the vector components into magnitude and sign
    always_comb begin
        q_in[0] = clamp_q(XW'(s_quat_w));
        q_in[1] = clamp_q(XW'(s_quat_x));
        q_in[2] = clamp_q(XW'(s_quat_y));
        q_in[3] = clamp_q(XW'(s_quat_z));
        side_in = '0;
        side_in[DW-1:0]      = s_trans_x;
        side_in[2*DW-1:DW]   = s_trans_y;
        side_in[3*DW-1:2*DW] = s_trans_z;
        for (int c = 0; c < 3; c++) begin
            side_in[OFF_MAG + c*MW +: MW] = (q_in[c+1] < 0) ? MW'(-q_in[c+1])
                                                            : MW'(q_in[c+1]);
            side_in[OFF_SGN + c] = q_in[c+1][QW-1];
        end
    end

    // Decide the path and set up the rotator input
    always_comb begin
        root_s   = root_d[RSTEPS].res[SW-1:0];
        is_small = (root_s == '0) || (root_s < limit_reg);
        side_dec = side_reg[ST_ROOT];
        side_dec[OFF_SMALL] = is_small;
        if (w_reg[ST_ROOT] >= 0) begin
            cord_init.px  = CW'(w_reg[ST_ROOT]) <<< GUARD;
            cord_init.py  = CW'({1'b0, root_s}) <<< GUARD;
            cord_init.acc = '0;
        end else begin
            cord_init.px  = CW'({1'b0, root_s}) <<< GUARD;
            cord_init.py  = (-CW'(w_reg[ST_ROOT])) <<< GUARD;
            cord_init.acc = AW'(2 * atan_const(0));
        end
    end

    // Front stages: input, squares, sum, the side and w shift lines, and the rotator and divider loads
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            w_reg[0]    <= q_in[0];
            for (int k = 1; k <= ST_ROOT; k++) begin
                w_reg[k] <= w_reg[k-1];
            end
            for (int k = 1; k <= ST_OUT; k++) begin
                side_reg[k] <= (k == ST_DEC) ? side_dec : side_reg[k-1];
            end
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= SQW'(side_reg[0][OFF_MAG + c*MW +: MW])
                           * SQW'(side_reg[0][OFF_MAG + c*MW +: MW]);
            end
            sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            cord_d[0] <= cord_init;
            for (int c = 0; c < 3; c++) begin
                div_d[c][0].rem  <= {side_reg[ST_ROOT][OFF_MAG + c*MW +: MW], 31'b0};
                div_d[c][0].quot <= '0;
                div_d[c][0].den  <= root_s;
            end
        end
    end

    assign root_d[0].rem = RW'(sum_reg);
    assign root_d[0].res = '0;

    // Square-root row
    for (genvar k = 0; k < RSTEPS; k++) begin : g_root
        qrv_root_cell #(.STEP(k)) u_cell (
            .aclk (aclk),
            .en   (en),
            .din  (root_d[k]),
            .dout (root_d[k+1])
        );
    end

    // Arctangent row
    for (genvar k = 1; k < CSTEPS; k++) begin : g_cord
        qrv_cordic_cell #(.STEP(k-1)) u_cell (
            .aclk (aclk),
            .en   (en),
            .din  (cord_d[k-1]),
            .dout (cord_d[k])
        );
    end

    cordic_t cord_last;
    qrv_cordic_cell #(.STEP(CSTEPS-1)) u_cord_last (
        .aclk (aclk),
        .en   (en),
        .din  (cord_d[CSTEPS-1]),
        .dout (cord_last)
    );

    // Three divider rows, one per component
    for (genvar c = 0; c < 3; c++) begin : g_lane
        for (genvar k = 0; k < RSTEPS; k++) begin : g_div
            qrv_div_cell #(.SHIFT(QTW-1-k)) u_cell (
                .aclk (aclk),
                .en   (en),
                .din  (div_d[c][k]),
                .dout (div_d[c][k+1])
            );
        end
    end

    // Back stages: angle rounding, ratio delay, products, result register
    always_ff @(posedge aclk) begin
        if (en) begin
            aq_reg <= (cord_last.acc < 0) ? '0
                    : AQW'((cord_last.acc + AW'(64'sd1 <<< 30)) >>> 31);
            for (int c = 0; c < 3; c++) begin
                ratio_reg[c][0] <= div_d[c][RSTEPS].quot;
                for (int k = 1; k < RDLY; k++) begin
                    ratio_reg[c][k] <= ratio_reg[c][k-1];
                end
                prod_reg[c] <= PRODW'(ratio_reg[c][RDLY-1]) * PRODW'(aq_reg);
                turn_reg[c] <= DW'(turn_next[c]);
            end
        end
    end

    // Round, restore sign and clamp each component
    always_comb begin
        logic [TW-1:0] mag;
        for (int c = 0; c < 3; c++) begin
            if (side_reg[ST_MUL][OFF_SMALL]) begin
                mag = (TW'(side_reg[ST_MUL][OFF_MAG + c*MW +: MW]) + TW'(1)) >> 1;
            end else begin
                mag = TW'(((PRODW + 1)'(prod_reg[c]) + (PRODW + 1)'(64'd1 << 30)) >> 31);
            end
            turn_next[c] = side_reg[ST_MUL][OFF_SGN + c] ? -$signed(mag) : $signed(mag);
            if (turn_next[c] > LIM_P) begin
                turn_next[c] = LIM_P;
            end else if (turn_next[c] < LIM_N) begin
                turn_next[c] = LIM_N;
            end
        end
    end

    assign m_valid      = vld_reg[ST_OUT];
    assign m_move_x     = side_reg[ST_OUT][DW-1:0];
    assign m_move_y     = side_reg[ST_OUT][2*DW-1:DW];
    assign m_move_z     = side_reg[ST_OUT][3*DW-1:2*DW];
    assign m_turn_x     = turn_reg[0];
    assign m_turn_y     = turn_reg[1];
    assign m_turn_z     = turn_reg[2];
    assign m_small_path = side_reg[ST_OUT][OFF_SMALL];
endmodule
`default_nettype wire

### rtl/qrv_checker.sv
`default_nettype none
module qrv_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic signed [DATA_WIDTH-1:0] m_turn_x,
    input wire logic signed [DATA_WIDTH-1:0] m_turn_y,
    input wire logic signed [DATA_WIDTH-1:0] m_turn_z,
    input wire logic                         m_small_path
);
    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_turn_x) && $stable(m_turn_y)
                                && $stable(m_turn_z) && $stable(m_small_path))
        else $error("result changed while stalled");

    // Drop results on reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Accept input whenever the result register is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty result register");

    // Small-angle results stay within two units (2^29 LSB)
    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_small_path |->
            m_turn_x <= 32'sd536870912 && m_turn_x >= -32'sd536870912 &&
            m_turn_y <= 32'sd536870912 && m_turn_y >= -32'sd536870912 &&
            m_turn_z <= 32'sd536870912 && m_turn_z >= -32'sd536870912)
        else $error("small-angle result out of range");
endmodule

bind quaternion_to_rotation_vector qrv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qrv_checker (.*);
`default_nettype wire
